[design/sssd_pkg.sv]
// Shared types, segment codes and digit encoding for the scan display.
`default_nettype none
package sssd_pkg;

  localparam int unsigned DIGIT_COUNT_DEFAULT = 8;
  localparam int unsigned STORE_DEPTH = 8;

  localparam logic [7:0] SEG_DASH  = 8'hbf;
  localparam logic [7:0] SEG_BLANK = 8'hff;

  typedef enum logic [1:0] {
    MODE_KEEP     = 2'd0,
    MODE_INTERVAL = 2'd1,
    MODE_CLOCK    = 2'd2,
    MODE_RECORD   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] display_mode;
    logic [6:0] interval_value;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [3:0] record_index;
    logic [7:0] record_temperature;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segment_pattern;
  } out_item_t;

  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

  function automatic logic [7:0] seg_digit(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hc0;
      4'd1:    code = 8'hf9;
      4'd2:    code = 8'ha4;
      4'd3:    code = 8'hb0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hf8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  // Tens code in the upper byte, ones code in the lower byte.
  function automatic logic [15:0] pair_codes(input logic [7:0] value);
    logic [6:0]  v;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    v    = (value > 8'd99) ? 7'd99 : value[6:0];
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - (7'(tens) * 7'd10);
    return {seg_digit(tens), seg_digit(ones[3:0])};
  endfunction

endpackage
`default_nettype wire

[design/seven_segment_scan_display.sv]
// Top level of the multiplexed seven-segment scan display.
// Each input item is one scan tick carrying the display mode and the values
// to show. The tick refreshes the eight-entry segment store, which MODE_KEEP
// leaves as it is, and then yields one result item: a one-hot digit select
// and the active-low segment byte of the current scan position, which then
// advances modulo DIGIT_COUNT. Both channels use valid and ready.
// An accepted item sits in an input register; from there the store refresh
// and digit selection are registered into the result register, and while
// the receiver is ready one item per cycle is sustained.
// When the receiver stalls, the result register holds its item and the
// input register takes one further item; ready then drops until the result
// is taken. Reset clears the store to all zero, the scan position to the
// first digit and both valid flags.
`default_nettype none
module seven_segment_scan_display
  import sssd_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam logic [2:0] SCAN_LAST = 3'(DIGIT_COUNT - 1);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  logic      out_valid_d;
  out_item_t out_item_q;
  store_t    store_q;
  store_t    store_d;
  logic [2:0] pos_q;
  logic [2:0] pos_d;
  logic      advance;

  sssd_refresh u_refresh (
    .item_i  (in_item_q),
    .store_i (store_q),
    .store_o (store_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign pos_d      = (pos_q == SCAN_LAST) ? 3'd0 : pos_q + 3'd1;
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      store_q     <= '0;
      pos_q       <= 3'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (advance) begin
        store_q <= store_d;
        pos_q   <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q.digit_select    <= 8'b1 << pos_q;
      out_item_q.segment_pattern <= store_d[pos_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_select_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot(out_item_q.digit_select))
    else $error("digit select is not one-hot");

  a_pos_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= SCAN_LAST)
    else $error("scan position beyond the last digit");

  a_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && pos_q == SCAN_LAST) |=> pos_q == 3'd0)
    else $error("scan position did not wrap");

  a_advance_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item produced no result");

endmodule
`default_nettype wire

[design/sssd_refresh.sv]
// Combinational refresh of the segment store from one scan tick item.
`default_nettype none
module sssd_refresh
  import sssd_pkg::*;
(
  input  wire in_item_t item_i,
  input  wire store_t   store_i,
  output store_t        store_o
);

  logic [15:0] interval_pair;
  logic [15:0] hour_pair;
  logic [15:0] minute_pair;
  logic [15:0] second_pair;
  logic [15:0] index_pair;
  logic [15:0] temp_pair;
  logic [7:0]  sep;

  always_comb begin
    interval_pair = pair_codes({1'b0, item_i.interval_value});
    hour_pair     = pair_codes({3'b000, item_i.hours});
    minute_pair   = pair_codes({2'b00, item_i.minutes});
    second_pair   = pair_codes({2'b00, item_i.seconds});
    index_pair    = pair_codes({4'b0000, item_i.record_index});
    temp_pair     = pair_codes(item_i.record_temperature);
    sep           = item_i.seconds[0] ? SEG_BLANK : SEG_DASH;

    store_o = store_i;
    unique case (item_i.display_mode)
      MODE_INTERVAL: begin
        store_o[0] = SEG_BLANK;
        store_o[1] = SEG_BLANK;
        store_o[2] = SEG_BLANK;
        store_o[3] = SEG_BLANK;
        store_o[4] = SEG_BLANK;
        store_o[5] = SEG_DASH;
        store_o[6] = interval_pair[15:8];
        store_o[7] = interval_pair[7:0];
      end
      MODE_CLOCK: begin
        store_o[0] = hour_pair[15:8];
        store_o[1] = hour_pair[7:0];
        store_o[2] = sep;
        store_o[3] = minute_pair[15:8];
        store_o[4] = minute_pair[7:0];
        store_o[5] = sep;
        store_o[6] = second_pair[15:8];
        store_o[7] = second_pair[7:0];
      end
      MODE_RECORD: begin
        store_o[0] = SEG_DASH;
        store_o[1] = index_pair[15:8];
        store_o[2] = index_pair[7:0];
        store_o[3] = SEG_BLANK;
        store_o[4] = SEG_BLANK;
        store_o[5] = SEG_DASH;
        store_o[6] = temp_pair[15:8];
        store_o[7] = temp_pair[7:0];
      end
      default: store_o = store_i;
    endcase
  end

endmodule
`default_nettype wire
